/* sv/rrwl_pkg.sv */
package rrwl_pkg;

    // Field widths fixed by the request and result words
    localparam int FUNC_W   = 4;
    localparam int INDEX_W  = 4;
    localparam int THREAD_W = 6;
    localparam int WAKE_W   = 16;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 8;

    // Defaults for the top level parameters
    localparam int NUM_LOCKS_DEF = 16;
    localparam int MAX_HOLD_DEF  = 255;

    // Entries in the queue between classifier and executor
    localparam int QUEUE_DEPTH = 2;

    // Function codes on the request word
    localparam logic [FUNC_W-1:0] FUNC_INIT         = 4'd0;
    localparam logic [FUNC_W-1:0] FUNC_TRY          = 4'd1;
    localparam logic [FUNC_W-1:0] FUNC_TRY_READ     = 4'd2;
    localparam logic [FUNC_W-1:0] FUNC_TRY_WRITE    = 4'd3;
    localparam logic [FUNC_W-1:0] FUNC_UNLOCK       = 4'd4;
    localparam logic [FUNC_W-1:0] FUNC_UNLOCK_READ  = 4'd5;
    localparam logic [FUNC_W-1:0] FUNC_UNLOCK_WRITE = 4'd6;
    localparam logic [FUNC_W-1:0] FUNC_UNLOCK_ANY   = 4'd7;
    localparam logic [FUNC_W-1:0] FUNC_UPGRADE      = 4'd8;
    localparam logic [FUNC_W-1:0] FUNC_DOWNGRADE    = 4'd9;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE_ALL  = 4'd10;

    typedef enum logic [1:0] {
        MODE_FREE  = 2'd0,
        MODE_STD   = 2'd1,
        MODE_READ  = 2'd2,
        MODE_WRITE = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BUSY      = 3'd1,
        ST_ILLEGAL   = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_NOT_OWNER = 3'd4
    } status_t;

    // Operation after classification
    typedef enum logic [3:0] {
        OP_INIT,
        OP_TRY,
        OP_TRY_READ,
        OP_TRY_WRITE,
        OP_UNLOCK,
        OP_UPGRADE,
        OP_DOWNGRADE,
        OP_RELEASE_ALL,
        OP_NOP,
        OP_BAD_INDEX
    } op_t;

    // Classified request word carried through the queue
    typedef struct packed {
        op_t                 op;
        mode_t               want;
        logic [INDEX_W-1:0]  lock_index;
        logic [THREAD_W-1:0] thread_id;
        logic                waiters;
    } item_t;

endpackage

/* sv/recursive_rw_lock_table_core.sv */
// Recursive reader/writer lock table. Each request word names a function, a lock, a
// thread and whether waiters sleep on that lock; the block answers with exactly one
// result word in request order. Requests are classified on entry, wait in a two-word
// queue and are carried out against the lock table, which sits in flip-flops and is
// cleared to free at once by reset, so no request waits for a clearing pass. Every
// function, release_all included (it compares all entries' owners in parallel), runs
// combinationally in the executor; one request per cycle is sustained while the result
// side takes words; each request passes the front register, queue slot and result word.
module recursive_rw_lock_table_core
    import rrwl_pkg::*;
#(
    parameter int NUM_LOCKS = NUM_LOCKS_DEF,
    parameter int MAX_HOLD  = MAX_HOLD_DEF
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [FUNC_W-1:0]   func,
    input  logic [INDEX_W-1:0]  lock_index,
    input  logic [THREAD_W-1:0] thread_id,
    input  logic                waiters_present,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic                granted,
    output logic [STATUS_W-1:0] status,
    output logic                released,
    output logic [WAKE_W-1:0]   wake_mask,
    output logic [1:0]          mode_after,
    output logic [COUNT_W-1:0]  count_after
);

    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    rrwl_front #(
        .NUM_LOCKS (NUM_LOCKS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .func            (func),
        .lock_index      (lock_index),
        .thread_id       (thread_id),
        .waiters_present (waiters_present),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_item       (push_item)
    );

    rrwl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    rrwl_back #(
        .NUM_LOCKS (NUM_LOCKS),
        .MAX_HOLD  (MAX_HOLD)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_item    (pop_item),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .granted     (granted),
        .status      (status),
        .released    (released),
        .wake_mask   (wake_mask),
        .mode_after  (mode_after),
        .count_after (count_after)
    );

endmodule

/* sv/rrwl_front.sv */
module rrwl_front
    import rrwl_pkg::*;
#(
    parameter int NUM_LOCKS = NUM_LOCKS_DEF
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [FUNC_W-1:0]   func,
    input  logic [INDEX_W-1:0]  lock_index,
    input  logic [THREAD_W-1:0] thread_id,
    input  logic                waiters_present,
    output logic                push_valid,
    input  logic                push_ready,
    output item_t               push_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;
    logic  in_range;
    logic  take;

    assign req_ready  = !valid_reg || push_ready;
    assign take       = req_valid && req_ready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;
    assign in_range   = 32'(lock_index) < NUM_LOCKS;

    // Classify the incoming word
    always_comb
    begin
        item_next.lock_index = lock_index;
        item_next.thread_id  = thread_id;
        item_next.waiters    = waiters_present;
        item_next.want       = MODE_FREE;
        item_next.op         = OP_NOP;
        case (func)
            FUNC_INIT:         item_next.op = OP_INIT;
            FUNC_TRY:          item_next.op = OP_TRY;
            FUNC_TRY_READ:     item_next.op = OP_TRY_READ;
            FUNC_TRY_WRITE:    item_next.op = OP_TRY_WRITE;
            FUNC_UNLOCK:
            begin
                item_next.op   = OP_UNLOCK;
                item_next.want = MODE_STD;
            end
            FUNC_UNLOCK_READ:
            begin
                item_next.op   = OP_UNLOCK;
                item_next.want = MODE_READ;
            end
            FUNC_UNLOCK_WRITE:
            begin
                item_next.op   = OP_UNLOCK;
                item_next.want = MODE_WRITE;
            end
            FUNC_UNLOCK_ANY:   item_next.op = OP_UNLOCK;
            FUNC_UPGRADE:      item_next.op = OP_UPGRADE;
            FUNC_DOWNGRADE:    item_next.op = OP_DOWNGRADE;
            FUNC_RELEASE_ALL:  item_next.op = OP_RELEASE_ALL;
            default:           item_next.op = OP_NOP;
        endcase
        if (func != FUNC_RELEASE_ALL && !in_range)
        begin
            item_next.op = OP_BAD_INDEX;
        end
    end

    // Hold the word until the queue takes it
    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

endmodule

/* sv/rrwl_queue.sv */
module rrwl_queue
    import rrwl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* sv/rrwl_back.sv */
module rrwl_back
    import rrwl_pkg::*;
#(
    parameter int NUM_LOCKS = NUM_LOCKS_DEF,
    parameter int MAX_HOLD  = MAX_HOLD_DEF
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  item_t               pop_item,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic                granted,
    output logic [STATUS_W-1:0] status,
    output logic                released,
    output logic [WAKE_W-1:0]   wake_mask,
    output logic [1:0]          mode_after,
    output logic [COUNT_W-1:0]  count_after
);

    localparam int IDX_W = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
    localparam int EXT_W = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;
    localparam int CNT_W = $clog2(MAX_HOLD + 1);
    localparam int CE_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    // Lock table
    mode_t               mode_reg  [NUM_LOCKS];
    logic [THREAD_W-1:0] owner_reg [NUM_LOCKS];
    logic [CNT_W-1:0]    count_reg [NUM_LOCKS];

    // Result register
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    logic                granted_reg;
    status_t             status_reg;
    logic                released_reg;
    logic [WAKE_W-1:0]   wake_reg;
    mode_t               mode_after_reg;
    logic [COUNT_W-1:0]  count_after_reg;

    logic                pop;
    logic [EXT_W-1:0]    ext_idx;
    logic [IDX_W-1:0]    idx;
    mode_t               cur_mode;
    logic [THREAD_W-1:0] cur_owner;
    logic [CNT_W-1:0]    cur_cnt;
    logic                cnt_full;
    logic                is_owner;
    logic [CNT_W-1:0]    cnt_dec;
    logic                wr_en;
    mode_t               n_mode;
    logic [THREAD_W-1:0] n_owner;
    logic [CNT_W-1:0]    n_cnt;
    logic [NUM_LOCKS-1:0] hit;
    logic                g_next;
    status_t             st_next;
    logic                rel_next;
    logic [WAKE_W-1:0]   wake_next;
    mode_t               mode_rep;
    logic [CE_W-1:0]     cnt_rep;

    assign pop         = pop_valid && (!rsp_valid_reg || rsp_ready);
    assign pop_ready   = !rsp_valid_reg || rsp_ready;
    assign rsp_valid   = rsp_valid_reg;
    assign granted     = granted_reg;
    assign status      = status_reg;
    assign released    = released_reg;
    assign wake_mask   = wake_reg;
    assign mode_after  = mode_after_reg;
    assign count_after = count_after_reg;

    // Read the named entry
    assign ext_idx   = EXT_W'(pop_item.lock_index);
    assign idx       = ext_idx[IDX_W-1:0];
    assign cur_mode  = mode_reg[idx];
    assign cur_owner = owner_reg[idx];
    assign cur_cnt   = count_reg[idx];
    assign cnt_full  = 32'(cur_cnt) >= MAX_HOLD;
    assign is_owner  = cur_owner == pop_item.thread_id;
    assign cnt_dec   = (cur_cnt != '0) ? cur_cnt - 1'b1 : '0;

    // Match every held entry against the thread for release_all
    always_comb
    begin
        for (int i = 0; i < NUM_LOCKS; i++)
        begin
            hit[i] = (mode_reg[i] != MODE_FREE) && (owner_reg[i] == pop_item.thread_id);
        end
    end

    // Execute the operation on the named entry, or build the wake mask of all hits for release_all
    always_comb
    begin
        wr_en     = 1'b0;
        n_mode    = cur_mode;
        n_owner   = cur_owner;
        n_cnt     = cur_cnt;
        g_next    = 1'b0;
        st_next   = ST_OK;
        rel_next  = 1'b0;
        wake_next = '0;
        case (pop_item.op)
            OP_INIT:
            begin
                wr_en   = 1'b1;
                n_mode  = MODE_FREE;
                n_owner = '0;
                n_cnt   = '0;
            end
            OP_TRY, OP_TRY_READ, OP_TRY_WRITE:
            begin
                if (cur_mode == MODE_FREE)
                begin
                    wr_en   = 1'b1;
                    n_owner = pop_item.thread_id;
                    n_cnt   = CNT_W'(1);
                    g_next  = 1'b1;
                    if (pop_item.op == OP_TRY)
                    begin
                        n_mode = MODE_STD;
                    end
                    else if (pop_item.op == OP_TRY_READ)
                    begin
                        n_mode = MODE_READ;
                    end
                    else
                    begin
                        n_mode = MODE_WRITE;
                    end
                end
                else if ((pop_item.op == OP_TRY && is_owner)
                      || (pop_item.op == OP_TRY_READ && cur_mode == MODE_READ)
                      || (pop_item.op == OP_TRY_WRITE && cur_mode == MODE_WRITE
                          && is_owner))
                begin
                    if (cnt_full)
                    begin
                        st_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        wr_en  = 1'b1;
                        n_cnt  = cur_cnt + 1'b1;
                        g_next = 1'b1;
                    end
                end
                else
                begin
                    st_next = ST_BUSY;
                end
            end
            OP_UNLOCK:
            begin
                if ((pop_item.want != MODE_FREE && pop_item.want != cur_mode)
                    || cur_mode == MODE_FREE)
                begin
                    st_next = ST_ILLEGAL;
                end
                else if (cur_mode != MODE_READ && !is_owner)
                begin
                    st_next = ST_NOT_OWNER;
                end
                else
                begin
                    wr_en = 1'b1;
                    n_cnt = cnt_dec;
                    if (cnt_dec == '0)
                    begin
                        n_mode    = MODE_FREE;
                        n_owner   = '0;
                        rel_next  = 1'b1;
                        wake_next = WAKE_W'(1) << pop_item.lock_index;
                    end
                end
            end
            OP_UPGRADE, OP_DOWNGRADE:
            begin
                if (cur_mode == ((pop_item.op == OP_UPGRADE) ? MODE_READ : MODE_WRITE)
                    && cur_cnt == CNT_W'(1) && !pop_item.waiters)
                begin
                    wr_en  = 1'b1;
                    n_mode = (pop_item.op == OP_UPGRADE) ? MODE_WRITE : MODE_READ;
                    g_next = 1'b1;
                end
                else
                begin
                    st_next = ST_BUSY;
                end
            end
            OP_RELEASE_ALL:
            begin
                for (int i = 0; i < NUM_LOCKS; i++)
                begin
                    wake_next = wake_next | (WAKE_W'(hit[i]) << i);
                end
            end
            OP_BAD_INDEX:
            begin
                st_next = ST_BUSY;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Report the named entry afterwards, zero where it does not apply
    always_comb
    begin
        mode_rep = n_mode;
        cnt_rep  = CE_W'(n_cnt);
        if (pop_item.op == OP_RELEASE_ALL || pop_item.op == OP_BAD_INDEX)
        begin
            mode_rep = MODE_FREE;
            cnt_rep  = '0;
        end
    end

    // Drop the result once taken, load a new one on pop
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (pop)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Update the table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_LOCKS; i++)
            begin
                mode_reg[i]  <= MODE_FREE;
                owner_reg[i] <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            for (int i = 0; i < NUM_LOCKS; i++)
            begin
                if (pop && pop_item.op == OP_RELEASE_ALL && hit[i])
                begin
                    mode_reg[i]  <= MODE_FREE;
                    owner_reg[i] <= '0;
                    count_reg[i] <= '0;
                end
                else if (pop && wr_en && 32'(idx) == i)
                begin
                    mode_reg[i]  <= n_mode;
                    owner_reg[i] <= n_owner;
                    count_reg[i] <= n_cnt;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            granted_reg     <= g_next;
            status_reg      <= st_next;
            released_reg    <= rel_next;
            wake_reg        <= wake_next;
            mode_after_reg  <= mode_rep;
            count_after_reg <= cnt_rep[COUNT_W-1:0];
        end
    end

endmodule

/* sv/rrwl_checker.sv */
module rrwl_checker
    import rrwl_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic                granted,
    input logic [STATUS_W-1:0] status,
    input logic                released,
    input logic [WAKE_W-1:0]   wake_mask,
    input logic [1:0]          mode_after,
    input logic [COUNT_W-1:0]  count_after
);

    // Hold a stalled result word
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(granted)
            && $stable(wake_mask) && $stable(count_after) && $stable(mode_after))
        else $error("result word changed while stalled");

    // A grant leaves the lock held with an ok status
    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && granted |-> status == ST_OK && mode_after != MODE_FREE
            && !released && wake_mask == '0)
        else $error("grant with bad status or free lock");

    // A release frees exactly the named lock and wakes one lock
    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && released |-> mode_after == MODE_FREE && count_after == '0
            && $onehot(wake_mask) && status == ST_OK)
        else $error("release word inconsistent");

    // Refusals change nothing and wake nobody
    a_refuse: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_ILLEGAL || status == ST_NOT_OWNER
            || status == ST_OVERFLOW || status == ST_BUSY)
            |-> !granted && !released && wake_mask == '0)
        else $error("refused request granted or woke waiters");

endmodule

bind recursive_rw_lock_table_core rrwl_checker u_rrwl_checker (.*);
